// ===== sv/msix_vector_table_engine_core_defines.svh =====
// Assertion macros shared by the MSI-X engine modules.
// Depends on nothing; modules that assert include it by bare file name.
`ifndef MSIX_VECTOR_TABLE_ENGINE_CORE_DEFINES_SVH
`define MSIX_VECTOR_TABLE_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off while rst_n is low
`define MVT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define MVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MVT_ASSERT_IMPL(label, ante, cons, msg)
`define MVT_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/msixvt_pkg.sv =====
// Shared types and constants for the MSI-X vector table engine.
// No dependencies; used by the controller, datapath and top level.
package msixvt_pkg;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 136;

  localparam logic [1:0] OP_RD   = 2'd0;
  localparam logic [1:0] OP_WR   = 2'd1;
  localparam logic [1:0] OP_INT  = 2'd2;
  localparam logic [1:0] OP_CTRL = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  localparam logic KIND_RESP = 1'b0;
  localparam logic KIND_MSG  = 1'b1;

  localparam logic [1:0] WORD_ADDR_LO = 2'd0;
  localparam logic [1:0] WORD_ADDR_HI = 2'd1;
  localparam logic [1:0] WORD_DATA    = 2'd2;
  localparam logic [1:0] WORD_CTRL    = 2'd3;

  localparam logic [3:0] ACC_LEN      = 4'd4;
  localparam int         CTRL_EN_BIT  = 15;
  localparam int         CTRL_FM_BIT  = 14;

  // controller to datapath
  typedef struct packed {
    logic load_item;
    logic exec;
    logic load_resp;
    logic scan_read;
    logic load_msg;
    logic idx_clr;
    logic idx_inc;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_req;
    logic any_elig;
    logic elig_cur;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/msixvt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msixvt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

// ===== sv/msixvt_ctrl.sv =====
// Sequencer for the MSI-X engine: accept, execute, respond, then scan vectors if a scan is due.
// Depends on msixvt_pkg and the assertion macro header.
`include "msix_vector_table_engine_core_defines.svh"
module msixvt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  msixvt_pkg::sts_t  sts,
  output msixvt_pkg::cmd_t  cmd
);
  import msixvt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RESP = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_MSG  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_resp = 1'b1;
          if (sts.scan_req && sts.any_elig) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_SCAN: begin
        // step past ineligible vectors, stop on the next one to send
        if (sts.elig_cur) begin
          cmd.scan_read = 1'b1;
          state_nxt     = S_MSG;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_MSG: begin
        if (sts.out_free) begin
          cmd.load_msg = 1'b1;
          if (sts.any_elig) begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MVT_ASSERT_IMPL(a_scan_nonempty, state_r == S_SCAN, sts.any_elig, "scan with nothing to send")
  `MVT_ASSERT_NEXT(a_accept_exec, in_tvalid && in_tready, state_r == S_EXEC, "accept not executed")
endmodule

// ===== sv/msixvt_dpath.sv =====
// Datapath of the MSI-X engine: vector table RAMs, mask/pending bits, control
// bits, scan index and result register. Depends on msixvt_pkg, msixvt_ram.
`include "msix_vector_table_engine_core_defines.svh"
module msixvt_dpath #(
  parameter int VECTORS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  msixvt_pkg::cmd_t  cmd,
  output msixvt_pkg::sts_t  sts,
  input  logic              cfg_we,
  input  logic              cfg_bit,
  input  logic [1:0]        opcode,
  input  logic [9:0]        byte_offset,
  input  logic [3:0]        access_length,
  input  logic [31:0]       write_data,
  input  logic [4:0]        vector,
  input  logic              interrupt_level,
  input  logic              out_ready,
  output logic              out_valid,
  output logic              result_kind,
  output logic [1:0]        status,
  output logic [31:0]       read_data,
  output logic [63:0]       message_address,
  output logic [31:0]       message_data,
  output logic              last
);
  import msixvt_pkg::*;

  localparam int AW = (VECTORS > 1) ? $clog2(VECTORS) : 1;

  // held transaction
  logic [1:0]  op_r;
  logic [9:0]  off_r;
  logic [3:0]  len_r;
  logic [31:0] wd_r;
  logic [4:0]  vec_r;
  logic        lvl_r;

  logic [VECTORS-1:0] masked_r, pend_r, v_lo_r, v_hi_r, v_dat_r;
  logic               mmio_r, msix_r, fmask_r;
  logic [AW-1:0]      idx_r;
  logic               scan_req_r, mask_rd_r;
  logic [1:0]         status_r, word_r;
  logic               q_lo_v_r, q_hi_v_r, q_dat_v_r;

  logic               out_valid_r, out_kind_r, out_last_r;
  logic [1:0]         out_status_r;
  logic [31:0]        out_rd_r, out_data_r;
  logic [63:0]        out_addr_r;

  logic [5:0]         tv;
  logic [AW-1:0]      tv_idx, vec_idx, rd_addr;
  logic [1:0]         word;
  logic               is_tab, bad, tv_oor, vec_oor, tab_ok, int_on;
  logic               do_rd, do_wr, rd_en;
  logic [VECTORS-1:0] elig;
  logic [31:0]        q_lo, q_hi, q_dat, lo_sel, hi_sel, dat_sel, rd_word;
  logic               out_free;

  assign tv      = off_r[9:4];
  assign word    = off_r[3:2];
  assign tv_idx  = AW'(tv);
  assign vec_idx = AW'({1'b0, vec_r});
  assign is_tab  = (op_r == OP_RD) || (op_r == OP_WR);
  assign bad     = (len_r != ACC_LEN) || (off_r[1:0] != 2'b00);
  assign tv_oor  = (tv >= 6'(VECTORS));
  assign vec_oor = ({1'b0, vec_r} >= 6'(VECTORS));
  assign tab_ok  = is_tab && !bad && !tv_oor;
  assign int_on  = (op_r == OP_INT) && !vec_oor && msix_r && mmio_r;
  assign do_rd   = cmd.exec && tab_ok && (op_r == OP_RD);
  assign do_wr   = cmd.exec && tab_ok && (op_r == OP_WR);
  assign rd_en   = do_rd || cmd.scan_read;
  assign rd_addr = cmd.scan_read ? idx_r : tv_idx;

  assign elig    = pend_r & ~masked_r & {VECTORS{~fmask_r}};

  msixvt_ram #(.WIDTH(32), .DEPTH(VECTORS)) u_addr_lo (
    .clk     (clk),
    .wr_en   (do_wr && (word == WORD_ADDR_LO)),
    .wr_addr (tv_idx),
    .wr_data ({wd_r[31:2], 2'b00}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (q_lo)
  );

  msixvt_ram #(.WIDTH(32), .DEPTH(VECTORS)) u_addr_hi (
    .clk     (clk),
    .wr_en   (do_wr && (word == WORD_ADDR_HI)),
    .wr_addr (tv_idx),
    .wr_data (wd_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (q_hi)
  );

  msixvt_ram #(.WIDTH(32), .DEPTH(VECTORS)) u_data (
    .clk     (clk),
    .wr_en   (do_wr && (word == WORD_DATA)),
    .wr_addr (tv_idx),
    .wr_data (wd_r),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (q_dat)
  );

  // never-written words read as zero
  assign lo_sel  = q_lo_v_r  ? q_lo  : '0;
  assign hi_sel  = q_hi_v_r  ? q_hi  : '0;
  assign dat_sel = q_dat_v_r ? q_dat : '0;

  always_comb begin
    case (word_r)
      WORD_ADDR_LO: rd_word = lo_sel;
      WORD_ADDR_HI: rd_word = hi_sel;
      WORD_DATA:    rd_word = dat_sel;
      default:      rd_word = {31'd0, mask_rd_r};
    endcase
  end

  assign out_free = !out_valid_r || out_ready;

  assign sts.scan_req = scan_req_r;
  assign sts.any_elig = |elig;
  assign sts.elig_cur = elig[idx_r];
  assign sts.out_free = out_free;

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_r  <= opcode;
      off_r <= byte_offset;
      len_r <= access_length;
      wd_r  <= write_data;
      vec_r <= vector;
      lvl_r <= interrupt_level;
    end
    if (cmd.exec) begin
      word_r    <= word;
      mask_rd_r <= masked_r[tv_idx];
      if (is_tab && bad) begin
        status_r <= ST_BAD;
      end else if ((is_tab && tv_oor) || ((op_r == OP_INT) && vec_oor)) begin
        status_r <= ST_RANGE;
      end else begin
        status_r <= ST_OK;
      end
    end
    if (rd_en) begin
      q_lo_v_r  <= v_lo_r[rd_addr];
      q_hi_v_r  <= v_hi_r[rd_addr];
      q_dat_v_r <= v_dat_r[rd_addr];
    end
    if (cmd.load_resp) begin
      out_kind_r   <= KIND_RESP;
      out_status_r <= status_r;
      out_rd_r     <= ((op_r == OP_RD) && (status_r == ST_OK)) ? rd_word : '0;
      out_addr_r   <= '0;
      out_data_r   <= '0;
      out_last_r   <= !scan_req_r || !(|elig);
    end else if (cmd.load_msg) begin
      out_kind_r   <= KIND_MSG;
      out_status_r <= ST_OK;
      out_rd_r     <= '0;
      out_addr_r   <= {hi_sel, lo_sel};
      out_data_r   <= dat_sel;
      // sent vectors are already cleared, so nothing left means final
      out_last_r   <= !(|elig);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masked_r    <= '1;
      pend_r      <= '0;
      v_lo_r      <= '0;
      v_hi_r      <= '0;
      v_dat_r     <= '0;
      mmio_r      <= 1'b0;
      msix_r      <= 1'b0;
      fmask_r     <= 1'b0;
      idx_r       <= '0;
      scan_req_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mmio_r <= cfg_bit;
      end
      if (do_wr) begin
        case (word)
          WORD_ADDR_LO: v_lo_r[tv_idx]   <= 1'b1;
          WORD_ADDR_HI: v_hi_r[tv_idx]   <= 1'b1;
          WORD_DATA:    v_dat_r[tv_idx]  <= 1'b1;
          default:      masked_r[tv_idx] <= wd_r[0];
        endcase
      end
      if (cmd.exec && int_on) begin
        pend_r[vec_idx] <= lvl_r;
      end
      if (cmd.exec && (op_r == OP_CTRL)) begin
        msix_r  <= wd_r[CTRL_EN_BIT];
        fmask_r <= wd_r[CTRL_FM_BIT];
      end
      if (cmd.exec) begin
        scan_req_r <= (tab_ok && (op_r == OP_WR)) || (op_r == OP_CTRL) ||
                      (int_on && lvl_r && !fmask_r && !masked_r[vec_idx]);
      end
      if (cmd.scan_read) begin
        pend_r[idx_r] <= 1'b0;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.load_resp || cmd.load_msg) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign result_kind     = out_kind_r;
  assign status          = out_status_r;
  assign read_data       = out_rd_r;
  assign message_address = out_addr_r;
  assign message_data    = out_data_r;
  assign last            = out_last_r;

  `MVT_ASSERT_IMPL(a_read_eligible, cmd.scan_read, elig[idx_r], "scan read of ineligible vector")
  `MVT_ASSERT_NEXT(a_pend_cleared, cmd.scan_read, !pend_r[idx_r], "sent vector still pending")
  `MVT_ASSERT_IMPL(a_load_free, cmd.load_resp || cmd.load_msg, out_free, "result overwritten")
endmodule

// ===== sv/msix_vector_table_engine_core.sv =====
// MSI-X vector table and pending-bit engine. Each input transaction is one
// register access (table read, table write, interrupt level change or control
// write) and yields one access response, followed by the MSI-X messages it
// releases, in vector order; tlast marks the final result of a transaction.
// The response is offered after the execute and respond states, later only
// while the previous result still waits on out_tready. The input is ready
// again in the cycle the final result of a transaction is offered. A
// dispatch scan walks the vectors from 0 upwards, one vector per cycle
// through the scan sequencer while no message waits on out_tready; each
// message adds a message state for the table RAM's registered read, and
// the scan ends at the last eligible vector. Table words that were never
// written read as zero; all vectors come out of reset masked.
// mmio_enable is written on the cfg port and must only change while the
// engine is idle.
// Depends on msixvt_pkg, msixvt_ctrl, msixvt_dpath and msixvt_ram.
module msix_vector_table_engine_core #(
  parameter int VECTORS = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_data,   // mmio_enable
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [9:0] byte_offset, [13:10] access_length, [45:14] write_data,
  // [50:46] vector, [51] interrupt_level, [55:52] zero
  input  logic [msixvt_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [1:0]                         in_tuser,   // [1:0] opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [1:0] status, [33:2] read_data, [97:34] message_address,
  // [129:98] message_data, [135:130] zero
  output logic [msixvt_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                               out_tuser,  // [0] result_kind
  output logic                               out_tlast
);
  import msixvt_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic [1:0]  res_status;
  logic [31:0] res_rd, res_data;
  logic [63:0] res_addr;

  // configuration is always taken at once
  assign cfg_ready = 1'b1;

  msixvt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // unpack the input transaction straight into the datapath's holding regs
  msixvt_dpath #(.VECTORS(VECTORS)) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_bit         (cfg_data),
    .opcode          (in_tuser),
    .byte_offset     (in_tdata[9:0]),
    .access_length   (in_tdata[13:10]),
    .write_data      (in_tdata[45:14]),
    .vector          (in_tdata[50:46]),
    .interrupt_level (in_tdata[51]),
    .out_ready       (out_tready),
    .out_valid       (out_tvalid),
    .result_kind     (out_tuser),
    .status          (res_status),
    .read_data       (res_rd),
    .message_address (res_addr),
    .message_data    (res_data),
    .last            (out_tlast)
  );

  // pack the result, first field lowest, zero fill to whole bytes
  assign out_tdata = {6'd0, res_data, res_addr, res_rd, res_status};
endmodule
